>>> rtl/core/tabulated_energy_sampler_unit_macros.svh
// Assertion macros shared by the tabulated energy sampler RTL.
`ifndef TABULATED_ENERGY_SAMPLER_UNIT_MACROS_SVH
`define TABULATED_ENERGY_SAMPLER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TES_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TES_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/tes_pkg.sv
// Types, codes and constants of the tabulated energy sampler.
package tes_pkg;

    localparam int E_W       = 24;
    localparam int R_W       = 24;
    localparam int INT_W     = 48;
    localparam int START_W   = 32;
    localparam int MUL_W     = 25;
    localparam int PROD_W    = 50;
    localparam int DIV_NUM_W = 72;
    localparam int DIV_DEN_W = 48;
    localparam int DIV_Q_W   = 25;
    localparam int CFG_W     = 24;
    localparam int CFG_A_W   = 1;
    localparam int IN_DATA_W = 120;
    localparam int IN_USER_W = 3;
    localparam int OUT_USER_W = 2;

    typedef enum logic [2:0] {
        REQ_CLEAR  = 3'd0,
        REQ_LINE   = 3'd1,
        REQ_GRID   = 3'd2,
        REQ_LIMITS = 3'd3,
        REQ_SAMPLE = 3'd4
    } req_t;

    typedef enum logic [1:0] {
        STAT_SAMPLE   = 2'd0,
        STAT_ACCEPTED = 2'd1,
        STAT_NO_LINE  = 2'd2,
        STAT_FULL     = 2'd3
    } status_t;

    typedef enum logic [0:0] {
        CFG_STEP  = 1'b0,
        CFG_FIXED = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic [E_W-1:0]     energy;
        logic [START_W-1:0] start;
    } line_ent_t;

    typedef struct packed {
        logic [E_W-1:0]   intensity;
        logic [INT_W-1:0] integral;
    } grid_ent_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef enum logic [5:0] {
        ST_IDLE, ST_EXEC,
        ST_SC_A, ST_SC_B, ST_SC_C,
        ST_LRD, ST_LCHK,
        ST_GTOP, ST_GTOP_CHK, ST_G_OVER, ST_G_OVER2,
        ST_BS, ST_BS_CHK,
        ST_GI_RD0, ST_GI_RD1, ST_GI_CAP,
        ST_G_BASE, ST_G_MULH, ST_G_MULL, ST_G_NUM, ST_G_DIV,
        ST_LIM_START, ST_LIM_CEIL, ST_LIM_RD0, ST_LIM_RD1, ST_LIM_CAP,
        ST_LIM_MT, ST_LIM_DT, ST_LIM_WT, ST_LIM_MU, ST_LIM_DU, ST_LIM_WU,
        ST_LIM_NEXT, ST_DONE
    } fsm_t;

    // Clamp a wide energy to the 24-bit output range.
    function automatic logic [E_W-1:0] sat_energy(input logic [PROD_W-1:0] v);
        return (|v[PROD_W-1:E_W]) ? {E_W{1'b1}} : v[E_W-1:0];
    endfunction

endpackage

>>> rtl/core/tabulated_energy_sampler_unit.sv
// Top level of the tabulated energy sampler: request sequencer around two table RAMs.
//
// Usage: requests arrive on the s_ group (s_tuser = request kind, s_tdata = operands)
// and each request yields exactly one result on the m_ group (m_tdata = energy,
// m_tuser = status). A request is taken when s_tvalid and s_tready are both high.
// The block handles one request at a time; s_tready drops from acceptance until the
// result has been moved into the output register.
// Clear, add line and unknown kinds go straight from execute to done. A sample from
// lines scans the line RAM one entry at a time until the hit or the last line. A
// grid sample runs a binary search over the grid RAM and then at most one divide.
// Append grid point, set limits and a step_size write recompute both limit
// integrals, up to three divides each; s_tready stays low meanwhile (after a
// step_size write too).
// Reset empties both tables and zeroes the totals and limits; RAM contents are
// left as they are and are never read before being written.
// When the receiver stalls, the finished result waits in the output register and
// a following result waits in the sequencer until the register frees up.
`include "tabulated_energy_sampler_unit_macros.svh"

module tabulated_energy_sampler_unit #(
    parameter int MAX_LINES  = 32,
    parameter int MAX_POINTS = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // energy_in, intensity_in, limit_low, limit_high, random_in (24 bits each)
    input  logic [tes_pkg::IN_DATA_W-1:0]   s_tdata,
    // req_type
    input  logic [tes_pkg::IN_USER_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // energy_out
    output logic [tes_pkg::E_W-1:0]         m_tdata,
    // status
    output logic [tes_pkg::OUT_USER_W-1:0]  m_tuser,
    input  logic                            cfg_we,
    input  logic [tes_pkg::CFG_A_W-1:0]     cfg_addr,
    input  logic [tes_pkg::CFG_W-1:0]       cfg_wdata
);
    import tes_pkg::*;

    localparam int LA_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int LC_W = $clog2(MAX_LINES + 1);
    localparam int PA_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int PC_W = $clog2(MAX_POINTS + 1);

    fsm_t state_reg, state_next;

    logic [E_W-1:0]     step_reg, fixed_reg;
    logic               dirty_reg;
    req_t               req_reg;
    logic [E_W-1:0]     ein_reg, iin_reg, llo_in_reg, lhi_in_reg;
    logic [R_W-1:0]     r_reg;
    logic [LC_W-1:0]    lc_reg;
    logic [PC_W-1:0]    pc_reg;
    logic [INT_W-1:0]   total_reg, ilow_reg, ihigh_reg;
    logic [E_W-1:0]     lim_lo_reg, lim_hi_reg;
    logic [E_W-1:0]     last_i_reg;
    logic [INT_W-1:0]   last_g_reg;
    logic [INT_W-1:0]   v_reg, tmp_reg, s_reg;
    logic [PROD_W-1:0]  mul_reg, mul_next;
    logic [LA_W-1:0]    cnt_reg;
    logic [START_W-1:0] prev_start_reg;
    logic [E_W-1:0]     prev_energy_reg;
    logic [PA_W-1:0]    lo_reg, hi_reg;
    logic [INT_W-1:0]   g0_reg, g1_reg;
    logic [E_W-1:0]     i0_reg, i1_reg, d_reg, t_reg;
    logic [PROD_W-1:0]  base_reg;
    logic               ph_reg, from_req_reg;
    logic [E_W-1:0]     res_energy_reg;
    status_t            res_status_reg;
    logic               out_valid_reg;
    logic [E_W-1:0]     out_energy_reg;
    status_t            out_status_reg;

    // RAM ports
    logic                line_we;
    logic [LA_W-1:0]     line_waddr, line_raddr;
    line_ent_t           line_wdata, line_rd;
    logic [$bits(line_ent_t)-1:0] line_rdata;
    logic                grid_we;
    logic [PA_W-1:0]     grid_waddr, grid_raddr;
    grid_ent_t           grid_wdata, grid_rd;
    logic [$bits(grid_ent_t)-1:0] grid_rdata;

    div_req_t            div_req;
    div_stat_t           div_stat;
    logic [DIV_Q_W-1:0]  div_quo;

    logic [MUL_W-1:0]    mul_a, mul_b;
    logic [E_W-1:0]      step_eff, lim_e, diff_i;
    logic [PA_W-1:0]     mid;
    logic [INT_W-1:0]    grid_total, new_integral, scaled, x_diff;
    logic                line_full, grid_full, grid_ok, lim_direct;
    logic                hit_prev, is_last, hit_last, interp;
    logic                quo_beyond;
    logic                lim_wr_en;
    logic [INT_W-1:0]    lim_wr_val;

    tes_ram #(.WIDTH($bits(line_ent_t)), .DEPTH(MAX_LINES)) u_line_ram (
        .clk   (clk),
        .we    (line_we),
        .waddr (line_waddr),
        .wdata (line_wdata),
        .raddr (line_raddr),
        .rdata (line_rdata)
    );

    tes_ram #(.WIDTH($bits(grid_ent_t)), .DEPTH(MAX_POINTS)) u_grid_ram (
        .clk   (clk),
        .we    (grid_we),
        .waddr (grid_waddr),
        .wdata (grid_wdata),
        .raddr (grid_raddr),
        .rdata (grid_rdata)
    );

    tes_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .stat  (div_stat),
        .quo   (div_quo)
    );

    assign line_rd = line_ent_t'(line_rdata);
    assign grid_rd = grid_ent_t'(grid_rdata);

    // A step of zero behaves as a step of one.
    assign step_eff   = (step_reg == '0) ? E_W'(1) : step_reg;
    assign mid        = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign lim_e      = ph_reg ? lim_hi_reg : lim_lo_reg;
    assign grid_ok    = (pc_reg >= PC_W'(2));
    assign grid_total = grid_ok ? last_g_reg : '0;
    assign line_full  = (lc_reg == LC_W'(MAX_LINES));
    assign grid_full  = (pc_reg == PC_W'(MAX_POINTS));
    assign new_integral = (pc_reg == '0) ? '0 :
                          last_g_reg + INT_W'(last_i_reg) + INT_W'(iin_reg);
    assign scaled     = tmp_reg + INT_W'(mul_reg[2*E_W-1:E_W]);
    assign x_diff     = s_reg - g0_reg;
    assign diff_i     = (i1_reg >= i0_reg) ? (i1_reg - i0_reg) : (i0_reg - i1_reg);
    assign lim_direct = (lim_e == '0) || !grid_ok;
    assign interp     = (g1_reg != g0_reg) && (s_reg > g0_reg);
    assign quo_beyond = (32'(div_quo) > (32'(pc_reg) - 32'd1));

    // Line k is decided when entry k+1 arrives; the last line closes at the total.
    assign hit_prev = (cnt_reg != '0) && (INT_W'(prev_start_reg) <= s_reg)
                      && (s_reg < INT_W'(line_rd.start));
    assign is_last  = ((LC_W'(cnt_reg) + LC_W'(1)) == lc_reg);
    assign hit_last = (INT_W'(line_rd.start) <= s_reg) && (s_reg < total_reg);

    assign mul_next = mul_a * mul_b;

    assign s_tready = (state_reg == ST_IDLE) && !dirty_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_energy_reg;
    assign m_tuser  = out_status_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (dirty_reg)
                begin
                    state_next = ST_LIM_START;
                end
                else if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                unique case (req_reg)
                    REQ_GRID:   state_next = grid_full ? ST_DONE : ST_LIM_START;
                    REQ_LIMITS: state_next = ST_LIM_START;
                    REQ_SAMPLE: state_next = ((lc_reg != '0) || grid_ok) ? ST_SC_A : ST_DONE;
                    default:    state_next = ST_DONE;
                endcase
            end
            ST_SC_A:      state_next = ST_SC_B;
            ST_SC_B:      state_next = ST_SC_C;
            ST_SC_C:      state_next = (lc_reg != '0) ? ST_LRD : ST_GTOP;
            ST_LRD:       state_next = ST_LCHK;
            ST_LCHK:      state_next = (hit_prev || is_last) ? ST_DONE : ST_LRD;
            ST_GTOP:      state_next = ST_GTOP_CHK;
            ST_GTOP_CHK:  state_next = (grid_rd.integral < s_reg) ? ST_G_OVER : ST_BS;
            ST_G_OVER:    state_next = ST_G_OVER2;
            ST_G_OVER2:   state_next = ST_DONE;
            ST_BS:        state_next = (lo_reg < hi_reg) ? ST_BS_CHK : ST_GI_RD0;
            ST_BS_CHK:    state_next = ST_BS;
            ST_GI_RD0:    state_next = ST_GI_RD1;
            ST_GI_RD1:    state_next = ST_GI_CAP;
            ST_GI_CAP:    state_next = ST_G_BASE;
            ST_G_BASE:    state_next = ST_G_MULH;
            ST_G_MULH:    state_next = ST_G_MULL;
            ST_G_MULL:    state_next = ST_G_NUM;
            ST_G_NUM:     state_next = interp ? ST_G_DIV : ST_DONE;
            ST_G_DIV:     state_next = div_stat.done ? ST_DONE : ST_G_DIV;
            ST_LIM_START: state_next = lim_direct ? ST_LIM_NEXT : ST_LIM_CEIL;
            ST_LIM_CEIL:
            begin
                if (div_stat.done)
                begin
                    state_next = quo_beyond ? ST_LIM_NEXT : ST_LIM_RD0;
                end
            end
            ST_LIM_RD0:   state_next = ST_LIM_RD1;
            ST_LIM_RD1:   state_next = ST_LIM_CAP;
            ST_LIM_CAP:   state_next = ST_LIM_MT;
            ST_LIM_MT:    state_next = ST_LIM_DT;
            ST_LIM_DT:    state_next = ST_LIM_WT;
            ST_LIM_WT:    state_next = div_stat.done ? ST_LIM_MU : ST_LIM_WT;
            ST_LIM_MU:    state_next = ST_LIM_DU;
            ST_LIM_DU:    state_next = ST_LIM_WU;
            ST_LIM_WU:    state_next = div_stat.done ? ST_LIM_NEXT : ST_LIM_WU;
            ST_LIM_NEXT:
            begin
                if (!ph_reg)
                begin
                    state_next = ST_LIM_START;
                end
                else
                begin
                    state_next = from_req_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_DONE:      state_next = (!out_valid_reg || m_tready) ? ST_IDLE : ST_DONE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Memory, multiplier and divider controls
    always_comb
    begin
        line_we    = 1'b0;
        line_waddr = LA_W'(lc_reg);
        line_wdata = '{energy: ein_reg, start: total_reg[START_W-1:0]};
        line_raddr = cnt_reg;
        grid_we    = 1'b0;
        grid_waddr = PA_W'(pc_reg);
        grid_wdata = '{intensity: iin_reg, integral: new_integral};
        grid_raddr = '0;
        mul_a      = '0;
        mul_b      = '0;
        div_req    = '{start: 1'b0, num: '0, den: DIV_DEN_W'(step_eff)};
        lim_wr_en  = 1'b0;
        lim_wr_val = '0;
        unique case (state_reg)
            ST_EXEC:
            begin
                line_we = (req_reg == REQ_LINE) && !line_full;
                grid_we = (req_reg == REQ_GRID) && !grid_full;
            end
            ST_SC_A:
            begin
                mul_a = MUL_W'(v_reg[INT_W-1:E_W]);
                mul_b = MUL_W'(r_reg);
            end
            ST_SC_B:
            begin
                mul_a = MUL_W'(v_reg[E_W-1:0]);
                mul_b = MUL_W'(r_reg);
            end
            ST_GTOP:    grid_raddr = hi_reg;
            ST_BS:      grid_raddr = mid;
            ST_GI_RD0:  grid_raddr = lo_reg - PA_W'(1);
            ST_GI_RD1:  grid_raddr = lo_reg;
            ST_LIM_RD0: grid_raddr = lo_reg - PA_W'(1);
            ST_LIM_RD1:
            begin
                grid_raddr = lo_reg;
                mul_a      = MUL_W'(lo_reg - PA_W'(1));
                mul_b      = MUL_W'(step_eff);
            end
            ST_G_OVER:
            begin
                mul_a = MUL_W'(hi_reg);
                mul_b = MUL_W'(step_eff);
            end
            ST_G_BASE:
            begin
                mul_a = MUL_W'(lo_reg - PA_W'(1));
                mul_b = MUL_W'(step_eff);
            end
            ST_G_MULH:
            begin
                mul_a = MUL_W'(x_diff[INT_W-1:E_W]);
                mul_b = MUL_W'(step_eff);
            end
            ST_G_MULL:
            begin
                mul_a = MUL_W'(x_diff[E_W-1:0]);
                mul_b = MUL_W'(step_eff);
            end
            ST_G_NUM:
            begin
                div_req.start = interp;
                div_req.num   = {tmp_reg, {E_W{1'b0}}} + DIV_NUM_W'(mul_reg);
                div_req.den   = g1_reg - g0_reg;
            end
            ST_LIM_START:
            begin
                // Ceiling of e / step picks the grid point above the limit.
                div_req.start = !lim_direct;
                div_req.num   = DIV_NUM_W'({1'b0, lim_e} + {1'b0, step_eff} - 25'd1);
                lim_wr_en     = lim_direct;
                lim_wr_val    = (ph_reg && (lim_e == '0)) ? grid_total : '0;
            end
            ST_LIM_CEIL:
            begin
                lim_wr_en  = div_stat.done && quo_beyond;
                lim_wr_val = grid_total;
            end
            ST_LIM_MT:
            begin
                mul_a = MUL_W'(d_reg);
                mul_b = MUL_W'(diff_i);
            end
            ST_LIM_DT:
            begin
                div_req.start = 1'b1;
                div_req.num   = DIV_NUM_W'(mul_reg);
            end
            ST_LIM_MU:
            begin
                mul_a = {1'b0, i0_reg} + {1'b0, t_reg};
                mul_b = MUL_W'(d_reg);
            end
            ST_LIM_DU:
            begin
                div_req.start = 1'b1;
                div_req.num   = DIV_NUM_W'(mul_reg);
            end
            ST_LIM_WU:
            begin
                lim_wr_en  = div_stat.done;
                lim_wr_val = g0_reg + INT_W'(div_quo);
            end
            default:
            begin
                line_we = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= E_W'(65536);
            fixed_reg     <= E_W'(65536);
            dirty_reg     <= 1'b0;
            lc_reg        <= '0;
            pc_reg        <= '0;
            total_reg     <= '0;
            ilow_reg      <= '0;
            ihigh_reg     <= '0;
            lim_lo_reg    <= '0;
            lim_hi_reg    <= '0;
            ph_reg        <= 1'b0;
            from_req_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we && (cfg_addr == CFG_STEP))
            begin
                step_reg  <= cfg_wdata;
                dirty_reg <= 1'b1;
            end
            else if ((state_reg == ST_IDLE) && dirty_reg)
            begin
                dirty_reg <= 1'b0;
            end
            if (cfg_we && (cfg_addr == CFG_FIXED))
            begin
                fixed_reg <= cfg_wdata;
            end

            if ((state_reg == ST_IDLE) && dirty_reg)
            begin
                ph_reg       <= 1'b0;
                from_req_reg <= 1'b0;
            end

            if (state_reg == ST_EXEC)
            begin
                unique case (req_reg)
                    REQ_CLEAR:
                    begin
                        lc_reg     <= '0;
                        pc_reg     <= '0;
                        total_reg  <= '0;
                        ilow_reg   <= '0;
                        ihigh_reg  <= '0;
                        lim_lo_reg <= '0;
                        lim_hi_reg <= '0;
                    end
                    REQ_LINE:
                    begin
                        if (!line_full)
                        begin
                            total_reg <= total_reg + INT_W'(iin_reg);
                            lc_reg    <= lc_reg + LC_W'(1);
                        end
                    end
                    REQ_GRID:
                    begin
                        if (!grid_full)
                        begin
                            pc_reg       <= pc_reg + PC_W'(1);
                            ph_reg       <= 1'b0;
                            from_req_reg <= 1'b1;
                        end
                    end
                    REQ_LIMITS:
                    begin
                        lim_lo_reg   <= llo_in_reg;
                        lim_hi_reg   <= lhi_in_reg;
                        ph_reg       <= 1'b0;
                        from_req_reg <= 1'b1;
                    end
                    default:
                    begin
                        ph_reg <= ph_reg;
                    end
                endcase
            end

            if (lim_wr_en)
            begin
                if (ph_reg)
                begin
                    ihigh_reg <= lim_wr_val;
                end
                else
                begin
                    ilow_reg <= lim_wr_val;
                end
            end
            if (state_reg == ST_LIM_NEXT)
            begin
                ph_reg <= 1'b1;
            end

            if ((state_reg == ST_DONE) && (!out_valid_reg || m_tready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        mul_reg <= mul_next;

        if (s_tvalid && s_tready)
        begin
            req_reg    <= req_t'(s_tuser);
            ein_reg    <= s_tdata[23:0];
            iin_reg    <= s_tdata[47:24];
            llo_in_reg <= s_tdata[71:48];
            lhi_in_reg <= s_tdata[95:72];
            r_reg      <= s_tdata[119:96];
        end

        if ((state_reg == ST_DONE) && (!out_valid_reg || m_tready))
        begin
            out_energy_reg <= res_energy_reg;
            out_status_reg <= res_status_reg;
        end

        unique case (state_reg)
            ST_EXEC:
            begin
                if (((req_reg == REQ_LINE) && line_full) ||
                    ((req_reg == REQ_GRID) && grid_full))
                begin
                    res_energy_reg <= '0;
                    res_status_reg <= STAT_FULL;
                end
                else if ((req_reg == REQ_SAMPLE) && (lc_reg == '0) && !grid_ok)
                begin
                    // With no table loaded a sample answers the fixed energy.
                    res_energy_reg <= fixed_reg;
                    res_status_reg <= STAT_SAMPLE;
                end
                else
                begin
                    res_energy_reg <= '0;
                    res_status_reg <= STAT_ACCEPTED;
                end
                if ((req_reg == REQ_GRID) && !grid_full)
                begin
                    last_i_reg <= iin_reg;
                    last_g_reg <= new_integral;
                end
                if (req_reg == REQ_SAMPLE)
                begin
                    if (lc_reg != '0)
                    begin
                        v_reg <= total_reg;
                    end
                    else if (grid_ok)
                    begin
                        v_reg <= (ihigh_reg >= ilow_reg) ? (ihigh_reg - ilow_reg)
                                                         : (ilow_reg - ihigh_reg);
                    end
                end
            end
            ST_SC_B:
            begin
                tmp_reg <= mul_reg[INT_W-1:0];
            end
            ST_SC_C:
            begin
                if (lc_reg != '0)
                begin
                    s_reg <= scaled;
                end
                else if (ihigh_reg >= ilow_reg)
                begin
                    s_reg <= ilow_reg + scaled;
                end
                else
                begin
                    s_reg <= ilow_reg - scaled;
                end
                cnt_reg <= '0;
                lo_reg  <= PA_W'(1);
                hi_reg  <= PA_W'(pc_reg - PC_W'(1));
            end
            ST_LCHK:
            begin
                prev_start_reg  <= line_rd.start;
                prev_energy_reg <= line_rd.energy;
                cnt_reg         <= cnt_reg + LA_W'(1);
                if (hit_prev)
                begin
                    res_energy_reg <= prev_energy_reg;
                    res_status_reg <= STAT_SAMPLE;
                end
                else if (is_last && hit_last)
                begin
                    res_energy_reg <= line_rd.energy;
                    res_status_reg <= STAT_SAMPLE;
                end
                else if (is_last)
                begin
                    res_energy_reg <= '0;
                    res_status_reg <= STAT_NO_LINE;
                end
            end
            ST_G_OVER2:
            begin
                res_energy_reg <= sat_energy(mul_reg);
                res_status_reg <= STAT_SAMPLE;
            end
            ST_BS_CHK:
            begin
                if (grid_rd.integral >= s_reg)
                begin
                    hi_reg <= mid;
                end
                else
                begin
                    lo_reg <= mid + PA_W'(1);
                end
            end
            ST_GI_RD1:
            begin
                g0_reg <= grid_rd.integral;
            end
            ST_GI_CAP:
            begin
                g1_reg <= grid_rd.integral;
            end
            ST_G_MULH:
            begin
                base_reg <= mul_reg;
            end
            ST_G_MULL:
            begin
                tmp_reg <= mul_reg[INT_W-1:0];
            end
            ST_G_NUM:
            begin
                res_energy_reg <= sat_energy(base_reg);
                res_status_reg <= STAT_SAMPLE;
            end
            ST_G_DIV:
            begin
                if (div_stat.done)
                begin
                    res_energy_reg <= sat_energy(base_reg + PROD_W'(div_quo));
                end
            end
            ST_LIM_CEIL:
            begin
                lo_reg <= PA_W'(div_quo);
            end
            ST_LIM_RD1:
            begin
                i0_reg <= grid_rd.intensity;
                g0_reg <= grid_rd.integral;
            end
            ST_LIM_CAP:
            begin
                i1_reg <= grid_rd.intensity;
                d_reg  <= lim_e - mul_reg[E_W-1:0];
            end
            ST_LIM_WT:
            begin
                t_reg <= (i1_reg >= i0_reg) ? (i0_reg + div_quo[E_W-1:0])
                                            : (i0_reg - div_quo[E_W-1:0]);
            end
            default:
            begin
                tmp_reg <= tmp_reg;
            end
        endcase
    end

    `TES_ASSERT_NEXT(a_one_req, s_tvalid && s_tready, !s_tready, "request taken while busy")
    `TES_ASSERT_SAME(a_div_idle, div_req.start, !div_stat.busy, "divider restarted while busy")
    `TES_ASSERT_SAME(a_line_cap, 1'b1, lc_reg <= LC_W'(MAX_LINES), "line count past capacity")
    `TES_ASSERT_NEXT(a_step_dirty, cfg_we && (cfg_addr == CFG_STEP), dirty_reg, "limit refresh lost")

endmodule

>>> rtl/core/tes_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module tes_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/tes_div.sv
// Restoring divider producing a 25-bit quotient, one bit per cycle.
module tes_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tes_pkg::div_req_t            req,
    output tes_pkg::div_stat_t           stat,
    output logic [tes_pkg::DIV_Q_W-1:0]  quo
);
    import tes_pkg::*;

    localparam int CNT_W = $clog2(DIV_Q_W + 1);

    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_Q_W-1:0]   sh_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_DEN_W:0]   trial;
    logic [DIV_DEN_W:0]   diff;
    logic                 ge;

    // The upper numerator bits are below the divisor, so the quotient fits.
    assign trial = {rem_reg, sh_reg[DIV_Q_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_Q_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= DIV_DEN_W'(req.num[DIV_NUM_W-1:DIV_Q_W]);
            sh_reg  <= req.num[DIV_Q_W-1:0];
            den_reg <= req.den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
            sh_reg  <= {sh_reg[DIV_Q_W-2:0], ge};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quo       = sh_reg;

endmodule

>>> tb/tb_tabulated_energy_sampler_unit.sv
// Self-checking testbench of the tabulated energy sampler: directed and random requests.
module tb_tabulated_energy_sampler_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import tes_pkg::*;

    localparam int MAX_LINES  = 32;
    localparam int MAX_POINTS = 1024;
    // The drain is generous: longer than the longest request (limit recompute).
    localparam int DRAIN      = 400;
    // Cycles without any handshake before the run is declared hung.
    localparam int HANG_LIMIT = 20000;

    // Predicts the result of every request from its own copy of the tables.
    class sampler_scoreboard;
        typedef struct packed {
            logic [E_W-1:0] energy;
            logic [1:0]     status;
        } result_t;

        logic [23:0] step_reg;
        logic [23:0] fixed_reg;
        logic [23:0] line_energy_tab [MAX_LINES];
        logic [31:0] line_start_tab [MAX_LINES];
        int          line_n;
        logic [23:0] grid_level [MAX_POINTS];
        logic [47:0] grid_sum [MAX_POINTS];
        int          point_n;
        logic [47:0] line_total;
        logic [47:0] sum_low;
        logic [47:0] sum_high;
        logic [23:0] lim_lo;
        logic [23:0] lim_hi;
        result_t     awaited [$];
        int          errors;

        function new();
            step_reg  = 24'd65536;
            fixed_reg = 24'd65536;
            errors    = 0;
            clear_source();
        endfunction

        function void clear_source();
            line_n     = 0;
            point_n    = 0;
            line_total = '0;
            sum_low    = '0;
            sum_high   = '0;
            lim_lo     = '0;
            lim_hi     = '0;
        endfunction

        function longint unsigned eff_step();
            return (step_reg == 0) ? 64'd1 : 64'(step_reg);
        endfunction

        function longint unsigned grid_total();
            return (point_n >= 2) ? 64'(grid_sum[point_n-1]) : 64'd0;
        endfunction

        // Multiplies v by a Q0.24 fraction, floored.
        function longint unsigned scale_frac(longint unsigned v, longint unsigned r);
            return (v >> 24) * r + (((v & 64'hFFFFFF) * r) >> 24);
        endfunction

        // Integral of the grid from zero up to energy e, trapezoid interpolated.
        function longint unsigned partial_sum(longint unsigned e);
            longint unsigned stp, i, d, i0, i1, t;
            stp = eff_step();
            if (point_n < 2 || e == 0)
                return 0;
            i = (e + stp - 1) / stp;
            if (i > 64'(point_n - 1))
                return grid_total();
            d  = e - (i - 1) * stp;
            i0 = grid_level[i-1];
            i1 = grid_level[i];
            if (i1 >= i0)
                t = i0 + (d * (i1 - i0)) / stp;
            else
                t = i0 - (d * (i0 - i1)) / stp;
            return 64'(grid_sum[i-1]) + ((i0 + t) * d) / stp;
        endfunction

        function void apply_limits();
            sum_low  = (lim_lo != 0) ? 48'(partial_sum(lim_lo)) : 48'd0;
            sum_high = (lim_hi != 0) ? 48'(partial_sum(lim_hi)) : 48'(grid_total());
        endfunction

        function longint unsigned sample_grid(longint unsigned r);
            longint unsigned stp, s, e, base, den;
            int lo, hi, mid;
            stp = eff_step();
            lo  = 1;
            hi  = point_n - 1;
            if (sum_high >= sum_low)
                s = sum_low + scale_frac(sum_high - sum_low, r);
            else
                s = sum_low - scale_frac(sum_low - sum_high, r);
            if (grid_sum[hi] < s)
            begin
                e = 64'(hi) * stp;
                return (e > 64'hFFFFFF) ? 64'hFFFFFF : e;
            end
            while (lo < hi)
            begin
                mid = lo + (hi - lo) / 2;
                if (grid_sum[mid] >= s)
                    hi = mid;
                else
                    lo = mid + 1;
            end
            base = grid_sum[lo-1];
            den  = 64'(grid_sum[lo]) - base;
            e    = 64'(lo - 1) * stp;
            if (den != 0 && s > base)
                e += (stp * (s - base)) / den;
            return (e > 64'hFFFFFF) ? 64'hFFFFFF : e;
        endfunction

        function void write_cfg(logic [0:0] idx, logic [23:0] val);
            if (idx == CFG_STEP)
            begin
                step_reg = val;
                apply_limits();
            end
            else
                fixed_reg = val;
        endfunction

        // Notes one accepted request and queues the result it must produce.
        function void note_request(logic [2:0] req, logic [23:0] ein, logic [23:0] iin,
                                   logic [23:0] llo, logic [23:0] lhi, logic [23:0] r);
            result_t         res;
            longint unsigned e, s, stop;
            e = 0;
            res.status = STAT_ACCEPTED;
            case (req)
                REQ_CLEAR: clear_source();
                REQ_LINE:
                begin
                    if (line_n >= MAX_LINES)
                        res.status = STAT_FULL;
                    else
                    begin
                        line_energy_tab[line_n] = ein;
                        line_start_tab[line_n]  = line_total[31:0];
                        line_total = line_total + 48'(iin);
                        line_n++;
                    end
                end
                REQ_GRID:
                begin
                    if (point_n >= MAX_POINTS)
                        res.status = STAT_FULL;
                    else
                    begin
                        grid_level[point_n] = iin;
                        if (point_n == 0)
                            grid_sum[0] = '0;
                        else
                            grid_sum[point_n] = grid_sum[point_n-1]
                                + 48'(grid_level[point_n-1]) + 48'(iin);
                        point_n++;
                        apply_limits();
                    end
                end
                REQ_LIMITS:
                begin
                    lim_lo = llo;
                    lim_hi = lhi;
                    apply_limits();
                end
                REQ_SAMPLE:
                begin
                    if (line_n > 0)
                    begin
                        // Lines win over the grid; the first line whose span holds s is drawn.
                        s = scale_frac(line_total, r);
                        res.status = STAT_NO_LINE;
                        for (int k = 0; k < line_n; k++)
                        begin
                            stop = (k + 1 < line_n) ? 64'(line_start_tab[k+1])
                                                    : 64'(line_total);
                            if (res.status == STAT_NO_LINE && s >= line_start_tab[k]
                                && s < stop)
                            begin
                                e = line_energy_tab[k];
                                res.status = STAT_SAMPLE;
                            end
                        end
                    end
                    else if (point_n >= 2)
                    begin
                        e = sample_grid(r);
                        res.status = STAT_SAMPLE;
                    end
                    else
                    begin
                        e = fixed_reg;
                        res.status = STAT_SAMPLE;
                    end
                end
                default: ;
            endcase
            res.energy = e[23:0];
            awaited.insert(awaited.size(), res);
        endfunction

        // Compares one result with the oldest expectation.
        function void check_result(logic [23:0] energy, logic [1:0] status);
            result_t exp_res;
            if (awaited.size() == 0)
            begin
                $error("result with no request pending: energy_out %0d status %0d",
                       energy, status);
                errors++;
                return;
            end
            exp_res = awaited.pop_front();
            if (energy !== exp_res.energy)
            begin
                $error("energy_out: expected %0d, actual %0d", exp_res.energy, energy);
                errors++;
            end
            if (status !== exp_res.status)
            begin
                $error("status: expected %0d, actual %0d", exp_res.status, status);
                errors++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [IN_USER_W-1:0]  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [E_W-1:0]        m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;
    logic                  cfg_we;
    logic [CFG_A_W-1:0]    cfg_addr;
    logic [CFG_W-1:0]      cfg_wdata;

    sampler_scoreboard sb;
    int                send_idle_pct;
    int                recv_stall_pct;
    int                quiet_cycles;
    int                sent_count;
    longint unsigned   cur_step;

    tabulated_energy_sampler_unit #(
        .MAX_LINES  (MAX_LINES),
        .MAX_POINTS (MAX_POINTS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // The receiver decides at each falling edge whether it stalls the next cycle.
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Results are sampled at the rising edge; the watchdog counts cycles with no
    // handshake on either side and ends a hung run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= HANG_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Presents one request, holding it until the block takes it. Random idle
    // cycles go in front of the request as the current idling phase asks.
    task automatic send_request(logic [2:0] req, logic [23:0] ein, logic [23:0] iin,
                                logic [23:0] llo, logic [23:0] lhi, logic [23:0] r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = req;
        s_tdata  = {r, lhi, llo, iin, ein};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(req, ein, iin, llo, lhi, r);
        sent_count++;
        @(negedge clk);
    endtask

    // Holds the sender back until every expected result has come out.
    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    // Register writes happen only with the block idle and fully drained.
    task automatic write_register(logic [0:0] idx, logic [23:0] val);
        wait_drained();
        repeat (DRAIN) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = val;
        @(negedge clk);
        cfg_we = 1'b0;
        sb.write_cfg(idx, val);
        if (idx == CFG_STEP)
            cur_step = (val == 0) ? 64'd1 : 64'(val);
    endtask

    function automatic logic [23:0] rand24();
        return 24'($urandom());
    endfunction

    // Intensities lean toward zero and small values so flat and tiny intervals occur.
    function automatic logic [23:0] rand_level();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0)
            return '0;
        else if (pick < 4)
            return 24'($urandom_range(1, 20));
        return rand24();
    endfunction

    // A limit inside or just past the loaded grid, sometimes zero for no limit.
    function automatic logic [23:0] rand_limit(int points);
        longint unsigned span;
        if ($urandom_range(4) == 0)
            return '0;
        span = 64'(points) * cur_step;
        if (span > 64'hFFFFFF)
            span = 64'hFFFFFF;
        return 24'($urandom_range(0, 32'(span)));
    endfunction

    // One random sequence: mostly well-formed line or grid sessions, some noise.
    task automatic random_sequence();
        int kind, n;
        kind = $urandom_range(99);
        if (kind < 15)
        begin
            send_request(3'($urandom_range(7)), rand24(), rand24(), rand24(), rand24(),
                         rand24());
        end
        else if (kind < 50)
        begin
            send_request(REQ_CLEAR, rand24(), rand24(), rand24(), rand24(), rand24());
            n = $urandom_range(1, 6);
            repeat (n)
                send_request(REQ_LINE, rand24(), rand_level(), rand24(), rand24(),
                             rand24());
            repeat ($urandom_range(3, 8))
                send_request(REQ_SAMPLE, rand24(), rand24(), rand24(), rand24(),
                             rand24());
        end
        else
        begin
            send_request(REQ_CLEAR, rand24(), rand24(), rand24(), rand24(), rand24());
            n = $urandom_range(2, 12);
            repeat (n)
                send_request(REQ_GRID, rand24(), rand_level(), rand24(), rand24(),
                             rand24());
            repeat ($urandom_range(1, 2))
            begin
                if ($urandom_range(3) != 0)
                    send_request(REQ_LIMITS, rand24(), rand24(), rand_limit(n),
                                 rand_limit(n), rand24());
                repeat ($urandom_range(3, 8))
                    send_request(REQ_SAMPLE, rand24(), rand24(), rand24(), rand24(),
                                 rand24());
            end
        end
    endtask

    initial
    begin
        logic [23:0] step_choice [5];
        logic [23:0] fixed_choice [5];
        int          phase_idle [4];
        int          phase_stall [4];
        int          target;

        sb             = new();
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = REQ_CLEAR;
        m_tready       = 1'b0;
        cfg_we         = 1'b0;
        cfg_addr       = CFG_STEP;
        cfg_wdata      = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        quiet_cycles   = 0;
        sent_count     = 0;
        cur_step       = 64'd65536;

        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part: empty source first, then lines, then short grids with limits.
        send_request(REQ_SAMPLE, '0, '0, '0, '0, '0);
        send_request(3'($urandom_range(5, 7)), '1, '1, '1, '1, '1);
        send_request(REQ_LINE, 24'd1000, '0, '0, '0, '0);
        send_request(REQ_SAMPLE, '0, '0, '0, '0, '1);
        send_request(REQ_LINE, '1, '1, '0, '0, '0);
        send_request(REQ_LINE, 24'd5, 24'd1, '0, '0, '0);
        send_request(REQ_SAMPLE, '0, '0, '0, '0, '0);
        send_request(REQ_SAMPLE, '0, '0, '0, '0, '1);
        send_request(REQ_CLEAR, '0, '0, '0, '0, '0);
        send_request(REQ_GRID, '0, '1, '0, '0, '0);
        send_request(REQ_SAMPLE, '0, '0, '0, '0, 24'h800000);
        send_request(REQ_GRID, '0, '0, '0, '0, '0);
        send_request(REQ_GRID, '0, '0, '0, '0, '0);
        send_request(REQ_GRID, '0, 24'd7, '0, '0, '0);
        send_request(REQ_SAMPLE, '0, '0, '0, '0, '0);
        send_request(REQ_SAMPLE, '0, '0, '0, '0, '1);
        send_request(REQ_LIMITS, '0, '0, 24'd70000, '1, '0);
        send_request(REQ_SAMPLE, '0, '0, '0, '0, 24'h400000);
        send_request(REQ_LIMITS, '0, '0, 24'd190000, 24'd65536, '0);
        send_request(REQ_SAMPLE, '0, '0, '0, '0, 24'hC00000);
        send_request(REQ_LIMITS, '0, '0, '0, '0, '0);
        send_request(REQ_SAMPLE, '0, '0, '0, '0, 24'h123456);

        // Fill the line table to capacity; the extra request must report a full table.
        // A longer grid follows so the search runs several levels deep.
        send_request(REQ_CLEAR, '0, '0, '0, '0, '0);
        repeat (MAX_LINES + 1)
            send_request(REQ_LINE, rand24(), rand_level(), '0, '0, '0);
        send_request(REQ_SAMPLE, '0, '0, '0, '0, rand24());
        send_request(REQ_CLEAR, '0, '0, '0, '0, '0);
        repeat (40)
            send_request(REQ_GRID, '0, rand_level(), '0, '0, '0);
        repeat (6)
            send_request(REQ_SAMPLE, '0, '0, '0, '0, rand24());
        send_request(REQ_SAMPLE, '0, '0, '0, '0, '1);

        // Register settings per phase, extremes included; zero step acts as one.
        step_choice  = '{24'd1, 24'd0, 24'hFFFFFF, 24'd65536, 24'($urandom_range(2, 200000))};
        fixed_choice = '{24'd0, 24'hFFFFFF, 24'($urandom()), 24'd65536, 24'($urandom())};
        phase_idle   = '{0, 60, 0, 29};
        phase_stall  = '{0, 0, 60, 29};

        for (int p = 0; p < 5; p++)
        begin
            write_register(CFG_FIXED, fixed_choice[p]);
            write_register(CFG_STEP, step_choice[p]);
            send_idle_pct  = phase_idle[p % 4];
            recv_stall_pct = phase_stall[p % 4];
            // An empty-source sample shows the new fixed energy.
            send_request(REQ_CLEAR, '0, '0, '0, '0, '0);
            send_request(REQ_SAMPLE, '0, '0, '0, '0, rand24());
            target = sent_count + 70;
            while (sent_count < target)
            begin
                random_sequence();
                // Now and then the sender holds off until the block has drained.
                if ($urandom_range(19) == 0)
                    wait_drained();
            end
        end

        s_tvalid = 1'b0;
        wait_drained();
        repeat (DRAIN) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

>>> tabulated_energy_sampler_unit.f
+incdir+rtl/core
rtl/core/tes_pkg.sv
rtl/core/tes_ram.sv
rtl/core/tes_div.sv
rtl/core/tabulated_energy_sampler_unit.sv
tb/tb_tabulated_energy_sampler_unit.sv
